/* rtl/core/light_accum_to_shade_bytes_assert.svh */
// Assertion macros for the shade reducer checker.
`ifndef LIGHT_ACCUM_TO_SHADE_BYTES_ASSERT_SVH
`define LIGHT_ACCUM_TO_SHADE_BYTES_ASSERT_SVH

// same-cycle implication
`define LATS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lats: same-cycle check failed");

// next-cycle implication
`define LATS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lats: next-cycle check failed");

`endif

/* rtl/core/lats_pkg.sv */
// Types and constants for the light accumulator to shade byte reducer.
`timescale 1ns / 1ps

package lats_pkg;

    localparam int ACC_W   = 24;
    localparam int NCH     = 3;
    localparam int CH_RED  = 0;
    localparam int REM_W   = ACC_W + 7;
    localparam int P255_W  = ACC_W + 8;
    localparam int LW_BITS = 16;
    localparam int LPROD_W = ACC_W + LW_BITS + 1;
    localparam int LSUM_W  = LPROD_W + 1;

    localparam int          SHADE_MAX = 255;
    localparam logic [7:0]  SHADE_SAT = 8'hFF;

    // Q0.16 luma weights, index 0 is red
    localparam logic [NCH-1:0][LW_BITS-1:0] LUMA_W = {16'd7209, 16'd38666, 16'd19661};

    typedef struct packed {
        logic signed [ACC_W-1:0] accum_red;
        logic signed [ACC_W-1:0] accum_green;
        logic signed [ACC_W-1:0] accum_blue;
        logic                    mesh_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] shade_red;
        logic [7:0] shade_green;
        logic [7:0] shade_blue;
        logic       all_channels_valid;
        logic       mesh_end_out;
    } t_out_item;

    typedef struct packed {
        logic           colour;
        logic           mesh_end;
        logic           scale;
        logic [NCH-1:0] neg;
    } t_ctl;

    typedef logic [NCH-1:0][7:0]       t_bytes;
    typedef logic [NCH-1:0][REM_W-1:0] t_rems;

endpackage

/* rtl/core/lats_prep.sv */
// Front stages: channel max, scale products, luma sum and divider setup.
`timescale 1ns / 1ps

module lats_prep #(
    parameter int FRAC_BITS = 8,
    parameter int DIV_W     = 2 * lats_pkg::ACC_W - FRAC_BITS - 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lats_pkg::t_in_item i_item,
    input  logic               i_colour,
    output logic               o_valid,
    input  logic               i_stall,
    output lats_pkg::t_ctl     o_ctl,
    output lats_pkg::t_rems    o_rem,
    output logic [DIV_W-1:0]   o_div,
    output lats_pkg::t_bytes   o_q
);
    import lats_pkg::*;

    localparam int QB         = ACC_W - FRAC_BITS;
    localparam int LUMA_SHIFT = LW_BITS + FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  LIMIT     = ACC_W'(SHADE_MAX) << FRAC_BITS;
    localparam logic [ACC_W-1:0]         FRAC_MASK = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
    localparam logic signed [LSUM_W-1:0] LUMA_ONE  = LSUM_W'(1) << LUMA_SHIFT;
    localparam logic signed [LSUM_W-1:0] LUMA_HI   = LSUM_W'(SHADE_MAX) << LUMA_SHIFT;

    logic signed [ACC_W-1:0]   in_c [NCH];
    logic signed [ACC_W-1:0]   n_max;
    logic signed [P255_W-1:0]  n_p255 [NCH];
    logic signed [LPROD_W-1:0] n_lp [NCH];

    logic                      r_s1_valid;
    logic signed [ACC_W-1:0]   r_s1_c [NCH];
    logic signed [ACC_W-1:0]   r_s1_max;
    logic signed [P255_W-1:0]  r_s1_p255 [NCH];
    logic signed [LPROD_W-1:0] r_s1_lp [NCH];
    logic                      r_s1_colour;
    logic                      r_s1_mesh;

    logic signed [LSUM_W-1:0]  luma_sum;
    logic [7:0]                luma_byte;
    t_ctl                      n_ctl;
    t_rems                     n_rem;
    t_bytes                    n_q;
    logic [DIV_W-1:0]          n_div;

    logic                      r_s2_valid;
    t_ctl                      r_ctl;
    t_rems                     r_rem;
    logic [DIV_W-1:0]          r_div;
    t_bytes                    r_q;

    logic                      s1_stall;
    logic                      s2_stall;

    assign s2_stall = r_s2_valid & i_stall;
    assign s1_stall = r_s1_valid & s2_stall;
    assign o_stall  = s1_stall;

    assign in_c[0] = i_item.accum_red;
    assign in_c[1] = i_item.accum_green;
    assign in_c[2] = i_item.accum_blue;

    always_comb begin
        n_max = in_c[0];
        if (in_c[1] > n_max) begin
            n_max = in_c[1];
        end
        if (in_c[2] > n_max) begin
            n_max = in_c[2];
        end
        for (int k = 0; k < NCH; k++) begin
            n_p255[k] = P255_W'(in_c[k]) * P255_W'(SHADE_MAX);
            n_lp[k]   = LPROD_W'(in_c[k]) * $signed({1'b0, LUMA_W[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!s1_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1_stall && i_valid) begin
            r_s1_max    <= n_max;
            r_s1_colour <= i_colour;
            r_s1_mesh   <= i_item.mesh_end;
            for (int k = 0; k < NCH; k++) begin
                r_s1_c[k]    <= in_c[k];
                r_s1_p255[k] <= n_p255[k];
                r_s1_lp[k]   <= n_lp[k];
            end
        end
    end

    assign luma_sum = LSUM_W'(r_s1_lp[0]) + LSUM_W'(r_s1_lp[1]) + LSUM_W'(r_s1_lp[2]);

    // truncate toward zero, negatives from -1.0 down and anything from 255 up saturate
    always_comb begin
        if (luma_sum[LSUM_W-1]) begin
            luma_byte = (luma_sum <= -LUMA_ONE) ? SHADE_SAT : 8'h00;
        end else begin
            luma_byte = (luma_sum >= LUMA_HI) ? SHADE_SAT : luma_sum[LUMA_SHIFT +: 8];
        end
    end

    always_comb begin
        logic signed [P255_W-1:0] mag;
        logic [ACC_W-1:0]         adj;
        n_ctl.colour   = r_s1_colour;
        n_ctl.mesh_end = r_s1_mesh;
        n_ctl.scale    = r_s1_colour && (r_s1_max >= LIMIT);
        n_div          = DIV_W'(r_s1_max[ACC_W-2:0]) << (QB - 1);
        for (int k = 0; k < NCH; k++) begin
            n_ctl.neg[k] = r_s1_c[k][ACC_W-1];
            mag          = n_ctl.neg[k] ? -r_s1_p255[k] : r_s1_p255[k];
            n_rem[k]     = mag[REM_W-1:0];
            adj          = r_s1_c[k] + (n_ctl.neg[k] ? FRAC_MASK : '0);
            if (n_ctl.scale) begin
                n_q[k] = '0;
            end else if (r_s1_colour) begin
                n_q[k] = adj[FRAC_BITS +: 8];
            end else if (k == CH_RED) begin
                n_q[k] = luma_byte;
            end else begin
                n_q[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!s2_stall) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s2_stall && r_s1_valid) begin
            r_ctl <= n_ctl;
            r_rem <= n_rem;
            r_div <= n_div;
            r_q   <= n_q;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_q     = r_q;

endmodule

/* rtl/core/lats_cell.sv */
// Divider cell: one restoring quotient bit for all three channels.
`timescale 1ns / 1ps

module lats_cell #(
    parameter int DIV_W = 38
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  lats_pkg::t_ctl   i_ctl,
    input  lats_pkg::t_rems  i_rem,
    input  logic [DIV_W-1:0] i_div,
    input  lats_pkg::t_bytes i_q,
    output logic             o_valid,
    input  logic             i_stall,
    output lats_pkg::t_ctl   o_ctl,
    output lats_pkg::t_rems  o_rem,
    output logic [DIV_W-1:0] o_div,
    output lats_pkg::t_bytes o_q
);
    import lats_pkg::*;

    localparam int CMP_W = (REM_W > DIV_W) ? REM_W : DIV_W;

    t_rems            n_rem;
    t_bytes           n_q;
    logic             r_valid;
    t_ctl             r_ctl;
    t_rems            r_rem;
    logic [DIV_W-1:0] r_div;
    t_bytes           r_q;

    assign o_stall = r_valid & i_stall;

    always_comb begin
        logic             take;
        logic [CMP_W-1:0] diff;
        for (int k = 0; k < NCH; k++) begin
            take     = CMP_W'(i_rem[k]) >= CMP_W'(i_div);
            diff     = CMP_W'(i_rem[k]) - CMP_W'(i_div);
            n_rem[k] = take ? diff[REM_W-1:0] : i_rem[k];
            // keep only the low quotient byte
            n_q[k]   = i_ctl.scale ? {i_q[k][6:0], take} : i_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_ctl <= i_ctl;
            r_rem <= n_rem;
            r_div <= i_div >> 1;
            r_q   <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_q     = r_q;

endmodule

/* rtl/core/lats_finish.sv */
// Output stage: quotient sign fix-up and shade item register.
`timescale 1ns / 1ps

module lats_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lats_pkg::t_ctl      i_ctl,
    input  lats_pkg::t_bytes    i_q,
    output logic                o_valid,
    input  logic                i_stall,
    output lats_pkg::t_out_item o_item
);
    import lats_pkg::*;

    t_bytes    b;
    t_out_item n_item;
    logic      r_valid;
    t_out_item r_item;

    assign o_stall = r_valid & i_stall;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            b[k] = (i_ctl.scale && i_ctl.neg[k]) ? -i_q[k] : i_q[k];
        end
        n_item.shade_red          = b[0];
        n_item.shade_green        = i_ctl.colour ? b[1] : 8'h00;
        n_item.shade_blue         = i_ctl.colour ? b[2] : 8'h00;
        n_item.all_channels_valid = i_ctl.colour;
        n_item.mesh_end_out       = i_ctl.mesh_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/light_accum_to_shade_bytes.sv */
// Top level of the light accumulator to shade byte reducer.
// Takes one vertex item per cycle unless the input is stalled and returns one shade item
// per item, in order: two front stages form the channel max, the x255 products and the
// luma sum, then a row of divider cells each settles one bit of c*255/max for all three
// channels, and a last stage registers the result. Every stage holds its item while the
// next one stalls, so bubbles close up and input stalls only when every stage is full
// and the output is stalled. The colour_mode register is sampled as an item enters and
// travels with it.
`timescale 1ns / 1ps

module light_accum_to_shade_bytes #(
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lats_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lats_pkg::t_out_item o_out_item
);
    import lats_pkg::*;

    localparam int QB    = ACC_W - FRAC_BITS;
    localparam int DIV_W = 2 * ACC_W - FRAC_BITS - 2;

    logic             r_colour_mode;

    logic             c_valid [QB+1];
    logic             c_stall [QB+1];
    t_ctl             c_ctl   [QB+1];
    t_rems            c_rem   [QB+1];
    logic [DIV_W-1:0] c_div   [QB+1];
    t_bytes           c_q     [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_colour_mode <= i_cfg_data;
        end
    end

    lats_prep #(
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (DIV_W)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_item   (i_in_item),
        .i_colour (r_colour_mode),
        .o_valid  (c_valid[0]),
        .i_stall  (c_stall[0]),
        .o_ctl    (c_ctl[0]),
        .o_rem    (c_rem[0]),
        .o_div    (c_div[0]),
        .o_q      (c_q[0])
    );

    for (genvar g = 0; g < QB; g++) begin : g_cell
        lats_cell #(
            .DIV_W (DIV_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_stall (c_stall[g]),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_div   (c_div[g]),
            .i_q     (c_q[g]),
            .o_valid (c_valid[g+1]),
            .i_stall (c_stall[g+1]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_div   (c_div[g+1]),
            .o_q     (c_q[g+1])
        );
    end

    lats_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[QB]),
        .o_stall (c_stall[QB]),
        .i_ctl   (c_ctl[QB]),
        .i_q     (c_q[QB]),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

/* rtl/core/lats_check.sv */
// Port-level checker for the shade reducer, bound to the top level.
`timescale 1ns / 1ps

`include "light_accum_to_shade_bytes_assert.svh"

module lats_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input lats_pkg::t_out_item i_out_item
);
    import lats_pkg::*;

    `LATS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item))
    `LATS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, i_in_stall, i_out_valid && i_out_stall)
    `LATS_ASSERT_IMP(a_luma_zero, i_clk, i_rst_n, i_out_valid && !i_out_item.all_channels_valid, i_out_item.shade_green == 8'h00 && i_out_item.shade_blue == 8'h00)

endmodule

bind light_accum_to_shade_bytes lats_check u_lats_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
